// ===== rtl/rrtr_pkg.sv =====
// Shared types and constants for the round-robin task ring.
package rrtr_pkg;

    // Fixed field widths of the request and response items.
    localparam int ID_W       = 16;
    localparam int PRIO_W     = 8;
    localparam int FUNC_W     = 3;
    localparam int COUNT_W    = 5;
    // Index width carried to the cells; covers rings of up to 64 slots.
    localparam int CELL_IDX_W = 6;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEL   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DISP  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_NEXT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_COUNT = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    out_task_id;
        logic [PRIO_W-1:0]  out_priority;
        logic [COUNT_W-1:0] task_count;
        logic               last;
    } rsp_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                  add_en;
        logic [CELL_IDX_W-1:0] tail_idx;
        logic                  del_en;
        logic [CELL_IDX_W-1:0] del_idx;
        logic [CELL_IDX_W-1:0] rd_idx;
        logic [ID_W-1:0]       cmp_id;
        logic [PRIO_W-1:0]     new_prio;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_DISP
    } state_t;

endpackage

// ===== rtl/round_robin_task_ring.sv =====
// Top level of the round-robin task ring: sequencer, response register and cell chain.
//
// Requests arrive on cmd (cmd_valid/cmd_stall); results leave on rsp
// (rsp_valid/rsp_stall). A request is taken when valid is high and stall low.
// Add, next and count answer in the cycle after the request is taken. Delete
// registers the id compares of all cells, then locates the first hit and
// shifts the following cells left, answering from the delete state. Display
// sends one response per held task, one per cycle while rsp_stall is low, each
// read over the bus in the display state. A delete or display on an empty ring
// gives a single response with status empty; only the final response of a
// request has last set. One request is in work at a time: the next is taken
// once the sequencer is idle and the response register is free or being
// drained, so add, next and count run at one request per cycle while rsp_stall is
// low; delete and display hold the sequencer until their last response is loaded.
// Reset empties the ring and zeroes the round-robin pointer; slot contents
// are not cleared. While a valid response is stalled the response register holds its
// value and no new request or display entry advances.
module round_robin_task_ring
    import rrtr_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [IW-1:0]       k_reg, k_next;
    logic [CAPACITY-1:0] match_reg, match_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    cell_ctrl_t          ctrl;
    logic [ID_W-1:0]     cell_id   [CAPACITY];
    logic [PRIO_W-1:0]   cell_prio [CAPACITY];
    logic [ID_W-1:0]     cell_rd_id   [CAPACITY];
    logic [PRIO_W-1:0]   cell_rd_prio [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    logic [ID_W-1:0]     rd_id;
    logic [PRIO_W-1:0]   rd_prio;

    logic                accept;
    logic                out_free;
    logic                load;
    logic                found;
    logic [IW-1:0]       del_i;
    logic [IW-1:0]       cur_adj;
    logic                disp_end;

    // Handshake.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != S_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Cell chain; each cell pulls from its right neighbor on a delete.
    generate
        for (genvar g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == CAPACITY - 1)
            begin : g_tail
                rrtr_cell #(.IDX(g)) u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .nbr_id   ('0),
                    .nbr_prio ('0),
                    .id       (cell_id[g]),
                    .prio     (cell_prio[g]),
                    .match    (cell_match[g]),
                    .rd_id    (cell_rd_id[g]),
                    .rd_prio  (cell_rd_prio[g])
                );
            end
            else
            begin : g_body
                rrtr_cell #(.IDX(g)) u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .nbr_id   (cell_id[g+1]),
                    .nbr_prio (cell_prio[g+1]),
                    .id       (cell_id[g]),
                    .prio     (cell_prio[g]),
                    .match    (cell_match[g]),
                    .rd_id    (cell_rd_id[g]),
                    .rd_prio  (cell_rd_prio[g])
                );
            end
        end
    endgenerate

    // Shared read bus: only the selected cell drives nonzero data.
    always_comb
    begin
        rd_id   = '0;
        rd_prio = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            rd_id   = rd_id | cell_rd_id[j];
            rd_prio = rd_prio | cell_rd_prio[j];
        end
    end

    // First matching slot among the held entries; the lowest index wins.
    always_comb
    begin
        found = 1'b0;
        del_i = '0;
        for (int j = CAPACITY - 1; j >= 0; j--)
        begin
            if (match_reg[j] && (CNT_W'(j) < held_reg))
            begin
                found = 1'b1;
                del_i = IW'(j);
            end
        end
    end

    // Pointer after a delete: follow the entry that moved down, wrap past the tail.
    always_comb
    begin
        cur_adj = (cur_reg > del_i) ? (cur_reg - IW'(1)) : cur_reg;
        if ((CNT_W'(cur_adj) + CNT_W'(1)) >= held_reg)
        begin
            cur_adj = '0;
        end
    end

    assign disp_end = ((CNT_W'(k_reg) + CNT_W'(1)) == held_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (held_reg != '0))
                begin
                    if (cmd.func == FN_DEL)
                    begin
                        state_next = S_DEL;
                    end
                    else if (cmd.func == FN_DISP)
                    begin
                        state_next = S_DISP;
                    end
                end
            end
            S_DEL:
            begin
                state_next = S_IDLE;
            end
            S_DISP:
            begin
                if (out_free && disp_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control and response formation.
    always_comb
    begin
        held_next     = held_reg;
        cur_next      = cur_reg;
        k_next        = k_reg;
        match_next    = match_reg;
        load          = 1'b0;
        rsp_next      = '0;
        rsp_next.last = 1'b1;
        ctrl          = '0;
        ctrl.cmp_id   = cmd.task_id;
        ctrl.new_prio = cmd.priority_req;
        ctrl.tail_idx = CELL_IDX_W'(held_reg);
        ctrl.rd_idx   = (state_reg == S_DISP) ? CELL_IDX_W'(k_reg) : CELL_IDX_W'(cur_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.func)
                        FN_ADD:
                        begin
                            load = 1'b1;
                            if (held_reg >= CNT_W'(CAPACITY))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.add_en = 1'b1;
                                held_next   = held_reg + CNT_W'(1);
                                rsp_next.status = ST_OK;
                            end
                        end
                        FN_DEL:
                        begin
                            if (held_reg == '0)
                            begin
                                load = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                match_next = cell_match;
                            end
                        end
                        FN_DISP:
                        begin
                            k_next = '0;
                            if (held_reg == '0)
                            begin
                                load = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                        end
                        FN_NEXT:
                        begin
                            load = 1'b1;
                            if (held_reg == '0)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rsp_next.status       = ST_OK;
                                rsp_next.out_task_id  = rd_id;
                                rsp_next.out_priority = rd_prio;
                                if ((CNT_W'(cur_reg) + CNT_W'(1)) >= held_reg)
                                begin
                                    cur_next = '0;
                                end
                                else
                                begin
                                    cur_next = cur_reg + IW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // Count, and codes without meaning, only report the size.
                            load = 1'b1;
                            rsp_next.status = ST_OK;
                        end
                    endcase
                end
            end
            S_DEL:
            begin
                load = 1'b1;
                if (!found)
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
                else
                begin
                    ctrl.del_en  = 1'b1;
                    ctrl.del_idx = CELL_IDX_W'(del_i);
                    held_next    = held_reg - CNT_W'(1);
                    cur_next     = cur_adj;
                    rsp_next.status = ST_OK;
                end
            end
            S_DISP:
            begin
                if (out_free)
                begin
                    load                  = 1'b1;
                    rsp_next.status       = ST_OK;
                    rsp_next.out_task_id  = rd_id;
                    rsp_next.out_priority = rd_prio;
                    rsp_next.last         = disp_end;
                    k_next                = k_reg + IW'(1);
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        rsp_next.task_count = COUNT_W'(held_next);
        rsp_valid_next = load ? 1'b1 : (rsp_valid_reg && rsp_stall);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            cur_reg       <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            cur_reg       <= cur_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // The ring never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(CAPACITY))
        else $error("task count exceeds capacity");

    // The pointer stays inside the held entries, and at zero when empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((held_reg == '0) && (cur_reg == '0)) || (CNT_W'(cur_reg) < held_reg))
        else $error("round-robin pointer out of range");

    // A full status is only given when the ring holds its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_FULL)) |-> (rsp.task_count == COUNT_W'(CAPACITY)))
        else $error("full status with room left");

    // Delete resolution always returns to idle on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL) |=> (state_reg == S_IDLE))
        else $error("delete did not complete");

    // No request is taken while the sequencer is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> cmd_stall)
        else $error("request taken while busy");

endmodule

// ===== rtl/rrtr_cell.sv =====
// One slot of the task ring: holds an entry, compares ids, shifts left on delete.
module rrtr_cell
    import rrtr_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [ID_W-1:0]   nbr_id,
    input  logic [PRIO_W-1:0] nbr_prio,
    output logic [ID_W-1:0]   id,
    output logic [PRIO_W-1:0] prio,
    output logic              match,
    output logic [ID_W-1:0]   rd_id,
    output logic [PRIO_W-1:0] rd_prio
);

    localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(IDX);

    logic [ID_W-1:0]   id_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic              sel;

    // An add writes the tail slot; a delete pulls every slot from the removed one onward.
    always_ff @(posedge clk)
    begin
        if (ctrl.add_en && (ctrl.tail_idx == MY_IDX))
        begin
            id_reg   <= ctrl.cmp_id;
            prio_reg <= ctrl.new_prio;
        end
        else if (ctrl.del_en && (ctrl.del_idx <= MY_IDX))
        begin
            id_reg   <= nbr_id;
            prio_reg <= nbr_prio;
        end
    end

    // Id compare and masked read port for the shared AND-OR read bus.
    always_comb
    begin
        sel     = (ctrl.rd_idx == MY_IDX);
        match   = (id_reg == ctrl.cmp_id);
        rd_id   = sel ? id_reg : '0;
        rd_prio = sel ? prio_reg : '0;
    end

    assign id   = id_reg;
    assign prio = prio_reg;

endmodule
